// File: sv/mck_pkg.sv
// Shared types, codes and the Morse lookup table for the Morse code keyer.
package mck_pkg;

   // Gap kinds that come before a character
   localparam logic [1:0] GAP_NONE   = 2'd0;
   localparam logic [1:0] GAP_REPEAT = 2'd1;
   localparam logic [1:0] GAP_LETTER = 2'd2;
   localparam logic [1:0] GAP_WORD   = 2'd3;

   // Configuration register indexes
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_DOT_UNITS    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_UNITS   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_GAP  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_GAP   = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_GAP   = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_GAP     = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_END_GAP      = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_LIMIT = 8'd7;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Configuration register file contents
   typedef struct packed {
      logic [7:0] dot_units;
      logic [7:0] dash_units;
      logic [7:0] element_gap;
      logic [7:0] repeat_gap;
      logic [7:0] letter_gap;
      logic [7:0] word_gap;
      logic [7:0] end_gap;
      logic [7:0] length_limit;
   } cfg_type;

   // One classified character, as queued between front and back
   typedef struct packed {
      logic [1:0] gap_kind;
      logic [6:0] elem_bits;   // element bits below the marker, 1 = dash
      logic [2:0] elem_count;  // number of elements
      logic       close;       // append end gap
   } cmd_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Marker-bit codes for bytes 0x20..0x5F
   localparam logic [7:0] CODE_TABLE [64] = '{
      8'h00, 8'h6B, 8'h52, 8'h00, 8'h89, 8'h00, 8'h28, 8'h00,
      8'h36, 8'h6D, 8'h00, 8'h2A, 8'h73, 8'h61, 8'h55, 8'h32,
      8'h3F, 8'h2F, 8'h27, 8'h23, 8'h21, 8'h20, 8'h30, 8'h38,
      8'h3C, 8'h3E, 8'h78, 8'h6A, 8'h00, 8'h31, 8'h00, 8'h4C,
      8'h5A, 8'h05, 8'h18, 8'h1A, 8'h0C, 8'h02, 8'h12, 8'h0E,
      8'h10, 8'h04, 8'h17, 8'h0D, 8'h14, 8'h07, 8'h06, 8'h0F,
      8'h16, 8'h1D, 8'h0A, 8'h08, 8'h03, 8'h09, 8'h11, 8'h0B,
      8'h19, 8'h1B, 8'h1C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h4D
   };

   // Case-insensitive lookup; bytes outside the table give code zero
   function automatic logic [7:0] lookup_code(input logic [7:0] c);
      logic [7:0] u;
      logic [7:0] t;
      u = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         u = c - 8'h20;
      end
      t = u - 8'h20;
      if (u < 8'h20 || u > 8'h5F) begin
         return 8'h00;
      end
      return CODE_TABLE[t[5:0]];
   endfunction

endpackage

// File: sv/morse_code_keyer.sv
// Morse code keyer top level: configuration registers, front, queue and back.
//
// channel  direction  payload (low bit first)                     transaction when
// req      in         tdata[7:0] character                        req_tvalid & req_tready
// rsp      out        tdata[0] key_on, [8:1] duration; tlast      rsp_tvalid & rsp_tready
//                     run_end
// csr      in         csr_index register, csr_data value          csr_valid & csr_ready
//
// A character leaves the queue into the back sequencer, which then emits one key interval
// per cycle while the output register is free, at most 15 intervals per character.
// The front takes a new character whenever the two-entry queue has room.
// A stalled result holds in the output register; the sequencer waits behind it.
// Synchronous active-high reset restores register defaults and clears the message.
module morse_code_keyer
   import mck_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] character
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [0] key_on, [8:1] duration, rest zero
   output logic                 rsp_tlast,   // run_end
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data
);

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   cmd_type      push_cmd;
   cmd_type      pop_cmd;
   logic         push;
   logic         pop;

   assign csr_ready = 1'b1;

   // configuration register writes; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DOT_UNITS:    cfg_in.dot_units    = csr_data;
            CSR_DASH_UNITS:   cfg_in.dash_units   = csr_data;
            CSR_ELEMENT_GAP:  cfg_in.element_gap  = csr_data;
            CSR_REPEAT_GAP:   cfg_in.repeat_gap   = csr_data;
            CSR_LETTER_GAP:   cfg_in.letter_gap   = csr_data;
            CSR_WORD_GAP:     cfg_in.word_gap     = csr_data;
            CSR_END_GAP:      cfg_in.end_gap      = csr_data;
            CSR_LENGTH_LIMIT: cfg_in.length_limit = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_units    <= 8'd1;
         cfg_ff.dash_units   <= 8'd3;
         cfg_ff.element_gap  <= 8'd1;
         cfg_ff.repeat_gap   <= 8'd1;
         cfg_ff.letter_gap   <= 8'd2;
         cfg_ff.word_gap     <= 8'd4;
         cfg_ff.end_gap      <= 8'd6;
         cfg_ff.length_limit <= 8'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mck_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   mck_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   mck_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .pop_cmd    (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: sv/mck_queue.sv
// Two-entry command queue between the keyer front and back.
module mck_queue
   import mck_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      pop_cmd,
   output q_status_type status
);

   localparam int DEPTH = 2;

   cmd_type    slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign pop_cmd      = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue fill count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !status.full)
      else $error("queue pushed while full");
`endif

endmodule

// File: sv/mck_front.sv
// Keyer front: accepts characters, tracks message state, queues commands.
module mck_front
   import mck_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   logic [7:0] prev_ff, prev_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] count_next;
   logic [7:0] code;
   logic [2:0] len;
   logic       close;
   logic       is_nul;
   logic       is_space;

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;
   assign is_nul     = (req_tdata == CHAR_NUL);
   assign is_space   = (req_tdata == CHAR_SPACE);
   assign code       = lookup_code(req_tdata);

   // element count is the position of the marker bit
   always_comb begin
      len = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (code[i]) begin
            len = 3'(i);
         end
      end
   end

   // classify the character and work out the next message state
   always_comb begin
      count_next = (count_ff != 8'hFF) ? count_ff + 8'd1 : count_ff;
      close      = 1'b0;
      push_cmd.gap_kind   = GAP_NONE;
      push_cmd.elem_bits  = 7'd0;
      push_cmd.elem_count = 3'd0;
      prev_in  = prev_ff;
      count_in = count_ff;
      if (is_nul) begin
         close = 1'b1;
      end else begin
         if (is_space) begin
            push_cmd.gap_kind = GAP_WORD;
         end else begin
            if (count_ff != 8'd0) begin
               push_cmd.gap_kind = (prev_ff == req_tdata) ? GAP_REPEAT : GAP_LETTER;
            end
            push_cmd.elem_bits  = code[6:0];
            push_cmd.elem_count = len;
         end
         prev_in  = req_tdata;
         count_in = count_next;
         close    = (count_next >= cfg.length_limit);
      end
      if (close) begin
         prev_in  = 8'd0;
         count_in = 8'd0;
      end
      push_cmd.close = close;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 8'd0;
         count_ff <= 8'd0;
      end else if (push) begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_nul_closes: assert property (@(posedge clock) disable iff (reset)
      (push && is_nul) |=> (count_ff == 8'd0 && prev_ff == 8'd0))
      else $error("NUL did not clear the message state");
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      (push && !is_nul && !push_cmd.close) |=> (count_ff != 8'd0))
      else $error("character not counted");
   a_space_no_elems: assert property (@(posedge clock) disable iff (reset)
      (push && is_space) |-> (push_cmd.elem_count == 3'd0))
      else $error("space queued with elements");
`endif

endmodule

// File: sv/mck_back.sv
// Keyer back: sequences queued commands into timed key intervals.
module mck_back
   import mck_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  q_status_type q_status,
   input  cmd_type      pop_cmd,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,
   output logic         rsp_tlast
);

   logic       busy_ff, busy_in;
   logic       gap_ff, gap_in;
   logic [1:0] kind_ff, kind_in;
   logic [6:0] bits_ff, bits_in;
   logic [2:0] elems_ff, elems_in;
   logic       egap_ff, egap_in;
   logic       close_ff, close_in;
   logic       valid_ff, valid_in;
   logic       key_ff, key_in;
   logic [7:0] dur_ff, dur_in;
   logic       last_ff, last_in;
   logic       out_free;
   logic       emit;
   logic [2:0] elem_idx;
   logic [7:0] gap_dur;

   assign out_free = !valid_ff || rsp_tready;
   assign emit     = busy_ff && out_free;
   assign pop      = !busy_ff && !q_status.empty;
   assign elem_idx = elems_ff - 3'd1;

   // duration of the gap ahead of a character
   always_comb begin
      case (kind_ff)
         GAP_REPEAT: gap_dur = cfg.repeat_gap;
         GAP_LETTER: gap_dur = cfg.letter_gap;
         GAP_WORD:   gap_dur = cfg.word_gap;
         default:    gap_dur = 8'd0;
      endcase
   end

   // load a command, or emit the next interval of the current one
   always_comb begin
      busy_in  = busy_ff;
      gap_in   = gap_ff;
      kind_in  = kind_ff;
      bits_in  = bits_ff;
      elems_in = elems_ff;
      egap_in  = egap_ff;
      close_in = close_ff;
      valid_in = valid_ff && !rsp_tready;
      key_in   = key_ff;
      dur_in   = dur_ff;
      last_in  = last_ff;
      if (pop) begin
         gap_in   = (pop_cmd.gap_kind != GAP_NONE);
         kind_in  = pop_cmd.gap_kind;
         bits_in  = pop_cmd.elem_bits;
         elems_in = pop_cmd.elem_count;
         egap_in  = 1'b0;
         close_in = pop_cmd.close;
         busy_in  = (pop_cmd.gap_kind != GAP_NONE) || (pop_cmd.elem_count != 3'd0)
                    || pop_cmd.close;
      end else if (emit) begin
         valid_in = 1'b1;
         if (gap_ff) begin
            key_in = 1'b0;
            dur_in = gap_dur;
            gap_in = 1'b0;
         end else if (egap_ff) begin
            key_in  = 1'b0;
            dur_in  = cfg.element_gap;
            egap_in = 1'b0;
         end else if (elems_ff != 3'd0) begin
            key_in   = 1'b1;
            dur_in   = bits_ff[elem_idx] ? cfg.dash_units : cfg.dot_units;
            elems_in = elems_ff - 3'd1;
            egap_in  = (elems_ff > 3'd1);
         end else begin
            key_in   = 1'b0;
            dur_in   = cfg.end_gap;
            close_in = 1'b0;
         end
         busy_in = gap_in || egap_in || (elems_in != 3'd0) || close_in;
         last_in = !busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         gap_ff   <= 1'b0;
         elems_ff <= 3'd0;
         egap_ff  <= 1'b0;
         close_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         gap_ff   <= gap_in;
         elems_ff <= elems_in;
         egap_ff  <= egap_in;
         close_ff <= close_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      bits_ff <= bits_in;
      key_ff  <= key_in;
      dur_ff  <= dur_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, dur_ff, key_ff};
   assign rsp_tlast  = last_ff;

`ifndef SYNTH
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (!gap_ff && !egap_ff && elems_ff == 3'd0 && !close_ff))
      else $error("sequencer idle with work pending");
   a_egap_elem: assert property (@(posedge clock) disable iff (reset)
      egap_ff |-> (elems_ff != 3'd0))
      else $error("element gap pending with no element after it");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_tlast == !busy_ff))
      else $error("run end flag disagrees with sequencer state");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the Morse code keyer: stream driver, interval predictor, monitor.
module testbench;
   import mck_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // One predicted key interval
   typedef struct packed {
      logic       key_on;
      logic [7:0] duration;
      logic       run_end;
   } interval_type;

   // One register write transaction
   typedef struct packed {
      logic [7:0] index;
      logic [7:0] value;
   } csr_write_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = 8'h00;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [7:0]           csr_data   = 8'h00;

   // Characters waiting for the driver, intervals waiting for the monitor
   logic [7:0]     pending_chars [$];
   interval_type   keying_expected [$];
   csr_write_type  csr_plan [$];

   // Shadow of the register file and of the message state
   logic [7:0]  reg_shadow [8];
   logic [7:0]  msg_prev_char;
   logic [7:0]  msg_char_count;

   int unsigned chars_queued      = 0;
   int unsigned chars_sent        = 0;
   int unsigned intervals_checked = 0;
   int unsigned settings_applied  = 0;
   int unsigned error_count       = 0;
   int unsigned send_wait         = 0;
   int unsigned rsp_wait          = 0;
   bit          send_back_to_back = 1'b0;
   bit          take_back_to_back = 1'b0;

   morse_code_keyer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Dot/dash pattern of a character; empty for bytes without a code
   function automatic string morse_of(input logic [7:0] ch);
      logic [7:0] up;
      up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
      case (up)
         "A": return ".-";      "B": return "-...";    "C": return "-.-.";
         "D": return "-..";     "E": return ".";       "F": return "..-.";
         "G": return "--.";     "H": return "....";    "I": return "..";
         "J": return ".---";    "K": return "-.-";     "L": return ".-..";
         "M": return "--";      "N": return "-.";      "O": return "---";
         "P": return ".--.";    "Q": return "--.-";    "R": return ".-.";
         "S": return "...";     "T": return "-";       "U": return "..-";
         "V": return "...-";    "W": return ".--";     "X": return "-..-";
         "Y": return "-.--";    "Z": return "--..";
         "0": return "-----";   "1": return ".----";   "2": return "..---";
         "3": return "...--";   "4": return "....-";   "5": return ".....";
         "6": return "-....";   "7": return "--...";   "8": return "---..";
         "9": return "----.";
         "!": return "-.-.--";  "\"": return ".-..-."; "$": return "...-..-";
         "&": return ".-...";   "(": return "-.--.";   ")": return "-.--.-";
         "+": return ".-.-.";   ",": return "--..--";  "-": return "-....-";
         ".": return ".-.-.-";  "/": return "-..-.";   ":": return "---...";
         ";": return "-.-.-.";  "=": return "-...-";   "?": return "..--..";
         "@": return ".--.-.";  "_": return "..--.-";
         default: return "";
      endcase
   endfunction

   task automatic push_interval(input logic key, input logic [7:0] dur);
      interval_type iv;
      iv.key_on   = key;
      iv.duration = dur;
      iv.run_end  = 1'b0;
      keying_expected.push_back(iv);
   endtask

   // Expected intervals for one accepted character; updates the message state
   task automatic predict_keying(input logic [7:0] ch);
      string        pattern;
      int           base;
      int           i;
      bit           close_msg;
      interval_type tail_iv;
      base      = keying_expected.size();
      close_msg = 1'b0;
      if (ch == CHAR_NUL) begin
         close_msg = 1'b1;
      end else begin
         if (ch == CHAR_SPACE) begin
            push_interval(1'b0, reg_shadow[CSR_WORD_GAP]);
         end else begin
            pattern = morse_of(ch);
            // raw byte compare: case differences count as a new letter
            if (msg_char_count != 8'd0) begin
               push_interval(1'b0, (msg_prev_char == ch) ? reg_shadow[CSR_REPEAT_GAP]
                                                         : reg_shadow[CSR_LETTER_GAP]);
            end
            for (i = 0; i < pattern.len(); i++) begin
               push_interval(1'b1, (pattern[i] == "-") ? reg_shadow[CSR_DASH_UNITS]
                                                       : reg_shadow[CSR_DOT_UNITS]);
               if (i < pattern.len() - 1) begin
                  push_interval(1'b0, reg_shadow[CSR_ELEMENT_GAP]);
               end
            end
         end
         msg_prev_char = ch;
         if (msg_char_count != 8'd255) begin
            msg_char_count++;
         end
         if (msg_char_count >= reg_shadow[CSR_LENGTH_LIMIT]) begin
            close_msg = 1'b1;
         end
      end
      if (close_msg) begin
         push_interval(1'b0, reg_shadow[CSR_END_GAP]);
         msg_prev_char  = 8'h00;
         msg_char_count = 8'h00;
      end
      if (keying_expected.size() > base) begin
         tail_iv         = keying_expected.pop_back();
         tail_iv.run_end = 1'b1;
         keying_expected.push_back(tail_iv);
      end
   endtask

   // Register shadow follows the write channel; unknown indexes are dropped
   always @(posedge clock) begin
      if (reset) begin
         reg_shadow[CSR_DOT_UNITS]    = 8'd1;
         reg_shadow[CSR_DASH_UNITS]   = 8'd3;
         reg_shadow[CSR_ELEMENT_GAP]  = 8'd1;
         reg_shadow[CSR_REPEAT_GAP]   = 8'd1;
         reg_shadow[CSR_LETTER_GAP]   = 8'd2;
         reg_shadow[CSR_WORD_GAP]     = 8'd4;
         reg_shadow[CSR_END_GAP]      = 8'd6;
         reg_shadow[CSR_LENGTH_LIMIT] = 8'd255;
      end else if (csr_valid && csr_ready && csr_index <= CSR_LENGTH_LIMIT) begin
         reg_shadow[csr_index[2:0]] = csr_data;
      end
   end

   // Character driver: predicts on each accepted transaction, random gaps between items unless back to back
   always @(posedge clock) begin
      logic       nxt_valid;
      logic [7:0] nxt_data;
      nxt_valid = req_tvalid;
      nxt_data  = req_tdata;
      if (reset) begin
         nxt_valid      = 1'b0;
         send_wait      = 0;
         msg_prev_char  = 8'h00;
         msg_char_count = 8'h00;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_keying(req_tdata);
            chars_sent++;
            nxt_valid = 1'b0;
            send_wait = send_back_to_back ? 0 : $urandom_range(0, 4);
         end
         if (!nxt_valid) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (pending_chars.size() != 0) begin
               nxt_data  = pending_chars.pop_front();
               nxt_valid = 1'b1;
            end
         end
      end
      req_tvalid <= nxt_valid;
      req_tdata  <= nxt_data;
   end

   // Interval monitor: compares each transaction with the oldest prediction
   always @(posedge clock) begin
      logic         nxt_ready;
      interval_type want;
      nxt_ready = rsp_tready;
      if (reset) begin
         nxt_ready = 1'b0;
         rsp_wait  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (keying_expected.size() == 0) begin
               $error("unexpected interval: key_on %0d duration %0d run_end %0d",
                      rsp_tdata[0], rsp_tdata[8:1], rsp_tlast);
               error_count++;
            end else begin
               want = keying_expected.pop_front();
               if (rsp_tdata[0] !== want.key_on) begin
                  $error("key_on: expected %0d, got %0d", want.key_on, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[8:1] !== want.duration) begin
                  $error("duration: expected %0d, got %0d", want.duration, rsp_tdata[8:1]);
                  error_count++;
               end
               if (rsp_tlast !== want.run_end) begin
                  $error("run_end: expected %0d, got %0d", want.run_end, rsp_tlast);
                  error_count++;
               end
               intervals_checked++;
            end
            nxt_ready = 1'b0;
            rsp_wait  = take_back_to_back ? 0 : $urandom_range(0, 4);
         end
         if (!nxt_ready) begin
            if (rsp_wait != 0) begin
               rsp_wait--;
            end else begin
               nxt_ready = 1'b1;
            end
         end
      end
      rsp_tready <= nxt_ready;
   end

   task automatic queue_byte(input logic [7:0] ch);
      pending_chars.push_back(ch);
      chars_queued++;
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         queue_byte(s[i]);
      end
   endtask

   task automatic plan_write(input logic [7:0] index, input logic [7:0] value);
      csr_write_type w;
      w.index = index;
      w.value = value;
      csr_plan.push_back(w);
   endtask

   task automatic plan_settings(input logic [7:0] dot, input logic [7:0] dash,
                                input logic [7:0] elem, input logic [7:0] rpt,
                                input logic [7:0] ltr, input logic [7:0] word,
                                input logic [7:0] endg, input logic [7:0] limit);
      plan_write(CSR_DOT_UNITS, dot);
      plan_write(CSR_DASH_UNITS, dash);
      plan_write(CSR_ELEMENT_GAP, elem);
      plan_write(CSR_REPEAT_GAP, rpt);
      plan_write(CSR_LETTER_GAP, ltr);
      plan_write(CSR_WORD_GAP, word);
      plan_write(CSR_END_GAP, endg);
      plan_write(CSR_LENGTH_LIMIT, limit);
   endtask

   // Issue the planned writes back to back; valid drops after the last one
   task automatic apply_csr_plan();
      csr_write_type w;
      while (csr_plan.size() != 0) begin
         w = csr_plan.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.index;
         csr_data  <= w.value;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Block until every character is taken and every interval seen, then let it settle
   task automatic wait_drained();
      int unsigned guard;
      guard = 0;
      while ((chars_sent != chars_queued || keying_expected.size() != 0) && guard < 30000) begin
         @(posedge clock);
         guard++;
      end
      if (keying_expected.size() != 0) begin
         $error("%0d predicted intervals never arrived", keying_expected.size());
         error_count++;
         keying_expected.delete();
      end
      repeat (64) @(posedge clock);
   endtask

   // Mostly text with word breaks and message ends, some repeats and raw bytes
   function automatic logic [7:0] pick_char(input logic [7:0] last);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 38)      return 8'h41 + 8'($urandom_range(0, 25));
      else if (roll < 52) return 8'h61 + 8'($urandom_range(0, 25));
      else if (roll < 62) return 8'h21 + 8'($urandom_range(0, 62));
      else if (roll < 70) return CHAR_SPACE;
      else if (roll < 78) return CHAR_NUL;
      else if (roll < 90) return last;
      else                return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_message(input int count, input bit allow_nul);
      logic [7:0] ch;
      logic [7:0] last;
      int         i;
      last = "E";
      for (i = 0; i < count; i++) begin
         ch = pick_char(last);
         while (!allow_nul && ch == CHAR_NUL) ch = pick_char(last);
         queue_byte(ch);
         last = ch;
      end
   endtask

   task automatic plan_random_settings();
      int unsigned roll;
      logic [7:0]  limit;
      roll = $urandom_range(0, 9);
      if (roll < 5)      limit = 8'($urandom_range(1, 8));
      else if (roll < 8) limit = 8'($urandom_range(9, 40));
      else               limit = 8'd255;
      plan_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), limit);
   endtask

   // Run limit
   initial begin
      #5_000_000;
      $display("morse_code_keyer verification failed");
      $finish;
   end

   // Stimulus phases
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: case folding, repeats, space, unknown bytes, longest code
      queue_text("Aaa J E#$");
      queue_byte(CHAR_NUL);
      queue_byte(CHAR_NUL);
      queue_text("#");
      queue_byte(8'hFF);
      queue_byte(8'h80);
      queue_text("05z_@?");
      queue_byte(CHAR_NUL);
      queue_text("  ");
      queue_byte(CHAR_NUL);
      wait_drained();

      // Shortest units, zero gaps, every character closes; stray indexes ignored
      plan_write(8'hF8, 8'h00);
      plan_write(8'h0F, 8'h77);
      plan_settings(8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
      apply_csr_plan();
      send_back_to_back = 1'b1;
      queue_text("AB A#");
      wait_drained();

      // Longest values; one message runs into the character limit
      plan_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      apply_csr_plan();
      send_back_to_back = 1'b0;
      take_back_to_back = 1'b1;
      queue_message(256, 1'b0);
      wait_drained();

      // Limit of zero behaves as one
      plan_settings(8'd2, 8'd5, 8'd3, 8'd7, 8'd9, 8'd11, 8'd13, 8'd0);
      apply_csr_plan();
      take_back_to_back = 1'b0;
      queue_text("EE T");
      queue_byte(CHAR_NUL);
      wait_drained();

      // Random settings and traffic, draining between settings
      while (chars_queued < 470) begin
         plan_random_settings();
         apply_csr_plan();
         send_back_to_back = ($urandom_range(0, 3) == 0);
         take_back_to_back = ($urandom_range(0, 3) == 0);
         queue_message($urandom_range(15, 35), 1'b1);
         wait_drained();
      end

      $display("Sent %0d characters under %0d register settings; %0d key intervals checked.",
               chars_sent, settings_applied, intervals_checked);
      if (error_count == 0) begin
         $display("morse_code_keyer verification clean");
      end else begin
         $display("morse_code_keyer verification failed");
      end
      $finish;
   end

endmodule
